FILE: rtl/lbs_pkg.sv
// Shared types and constants of the skinning engine: request kinds, defaults,
// operation selects and the command and status groups between controller and datapath.
`default_nettype none
package lbs_pkg;

  localparam int unsigned JointsDef   = 64;
  localparam int unsigned FracBitsDef = 16;

  localparam logic [1:0] KindPose   = 2'd0;
  localparam logic [1:0] KindBind   = 2'd1;
  localparam logic [1:0] KindCompose = 2'd2;
  localparam logic [1:0] KindInfl   = 2'd3;

  localparam logic [1:0] RowLast = 2'd2;

  typedef enum logic [3:0] {
    MS_CMP = 4'b0001,
    MS_POS = 4'b0010,
    MS_NRM = 4'b0100,
    MS_W   = 4'b1000
  } mul_sel_e;

  typedef enum logic [4:0] {
    AO_NONE = 5'b00001,
    AO_CMP  = 5'b00010,
    AO_TP   = 5'b00100,
    AO_TN   = 5'b01000,
    AO_W    = 5'b10000
  } acc_op_e;

  typedef struct packed {
    logic     capture;
    logic     wr_load;
    logic     rd_cmp;
    logic     rd_skin;
    logic     wr_skin;
    logic     emit;
    logic [1:0] row_i;
    logic [1:0] row_k;
    logic [1:0] acc_row;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       ok;
    logic       last;
    logic       out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/lbs_ctrl.sv
// Sequencer of the skinning engine: walks loads, compose steps and influence passes.
// Depends on lbs_pkg for command, status and kind codes.
`default_nettype none
module lbs_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  lbs_pkg::status_t status_i,
  output lbs_pkg::cmd_t    cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DECODE = 13'b0000000000010,
    S_C_RD   = 13'b0000000000100,
    S_C_MUL  = 13'b0000000001000,
    S_C_ACC  = 13'b0000000010000,
    S_C_WR   = 13'b0000000100000,
    S_I_RD   = 13'b0000001000000,
    S_I_MULP = 13'b0000010000000,
    S_I_SUMP = 13'b0000100000000,
    S_I_MULN = 13'b0001000000000,
    S_I_SUMN = 13'b0010000000000,
    S_I_MULW = 13'b0100000000000,
    S_EMIT   = 13'b1000000000000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] i_q, i_d, k_q, k_d;
  logic       accw_q, accw_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      k_q     <= '0;
      accw_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      k_q     <= k_d;
      accw_q  <= accw_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d        = state_q;
    i_d            = i_q;
    k_d            = k_q;
    accw_d         = 1'b0;
    cmd_o          = '0;
    cmd_o.row_i    = i_q;
    cmd_o.row_k    = k_q;
    cmd_o.mul_sel  = lbs_pkg::MS_CMP;
    cmd_o.acc_op   = lbs_pkg::AO_NONE;
    if (accw_q) begin
      cmd_o.acc_op  = lbs_pkg::AO_W;
      cmd_o.acc_row = i_q - 2'd1;
    end
    unique case (state_q)
      S_IDLE: begin
        i_d = '0;
        k_d = '0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status_i.kind)
          lbs_pkg::KindPose, lbs_pkg::KindBind: begin
            cmd_o.wr_load = 1'b1;
            state_d       = S_IDLE;
          end
          lbs_pkg::KindCompose: state_d = status_i.ok ? S_C_RD : S_IDLE;
          default: begin
            if (status_i.ok) state_d = S_I_RD;
            else if (status_i.last) state_d = S_EMIT;
            else state_d = S_IDLE;
          end
        endcase
      end
      S_C_RD: begin
        cmd_o.rd_cmp = 1'b1;
        state_d      = S_C_MUL;
      end
      S_C_MUL: begin
        cmd_o.mul_sel = lbs_pkg::MS_CMP;
        state_d       = S_C_ACC;
      end
      S_C_ACC: begin
        cmd_o.acc_op = lbs_pkg::AO_CMP;
        if (k_q == lbs_pkg::RowLast) begin
          k_d     = '0;
          state_d = S_C_WR;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = S_C_RD;
        end
      end
      S_C_WR: begin
        cmd_o.wr_skin = 1'b1;
        if (i_q == lbs_pkg::RowLast) begin
          state_d = S_IDLE;
        end else begin
          i_d     = i_q + 2'd1;
          state_d = S_C_RD;
        end
      end
      S_I_RD: begin
        cmd_o.rd_skin = 1'b1;
        state_d       = S_I_MULP;
      end
      S_I_MULP: begin
        cmd_o.mul_sel = lbs_pkg::MS_POS;
        state_d       = S_I_SUMP;
      end
      S_I_SUMP: begin
        cmd_o.acc_op = lbs_pkg::AO_TP;
        state_d      = S_I_MULN;
      end
      S_I_MULN: begin
        cmd_o.mul_sel = lbs_pkg::MS_NRM;
        state_d       = S_I_SUMN;
      end
      S_I_SUMN: begin
        cmd_o.acc_op = lbs_pkg::AO_TN;
        state_d      = S_I_MULW;
      end
      S_I_MULW: begin
        cmd_o.mul_sel = lbs_pkg::MS_W;
        accw_d        = 1'b1;
        i_d           = i_q + 2'd1;
        if (i_q != lbs_pkg::RowLast) state_d = S_I_RD;
        else if (status_i.last) state_d = S_EMIT;
        else state_d = S_IDLE;
      end
      S_EMIT: begin
        if (!accw_q && status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/lbs_datapath.sv
// Datapath of the skinning engine: matrix stores, four shared multipliers,
// accumulators and the result register. Depends on lbs_pkg.
`default_nettype none
module lbs_datapath #(
  parameter int unsigned JOINTS    = lbs_pkg::JointsDef,
  parameter int unsigned FRAC_BITS = lbs_pkg::FracBitsDef
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  lbs_pkg::cmd_t      cmd_i,
  output lbs_pkg::status_t   status_o,
  input  wire  [1:0]         kind_i,
  input  wire  [5:0]         joint_i,
  input  wire  [1:0]         row_i,
  input  wire  signed [31:0] e0_i,
  input  wire  signed [31:0] e1_i,
  input  wire  signed [31:0] e2_i,
  input  wire  signed [31:0] e3_i,
  input  wire  signed [31:0] normal_x_i,
  input  wire  signed [31:0] normal_y_i,
  input  wire  signed [31:0] normal_z_i,
  input  wire                last_influence_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [31:0] nrm_x_o,
  output logic signed [31:0] nrm_y_o,
  output logic signed [31:0] nrm_z_o
);

  localparam int unsigned Rows = JOINTS * 3;
  localparam int unsigned AW   = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned JW   = AW + 2;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi, lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (x > hi) return 32'sh7fffffff;
    else if (x < lo) return 32'sh80000000;
    else return x[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
    logic signed [63:0] hi, lo;
    hi = 64'sh00007fffffffffff;
    lo = -64'sh0000800000000000;
    if (x > hi) return 48'sh7fffffffffff;
    else if (x < lo) return 48'sh800000000000;
    else return x[47:0];
  endfunction

  logic [1:0]         kind_q, row_q;
  logic [5:0]         joint_q;
  logic signed [31:0] e_q [4];
  logic signed [31:0] n_q [3];
  logic               last_q;

  logic [127:0] pose_mem [Rows];
  logic [127:0] bind_mem [Rows];
  logic [127:0] skin_mem [Rows];
  logic [127:0] pose_rd_q, bind_rd_q, skin_rd_q;

  logic signed [63:0] prod_q [4];
  logic signed [63:0] sh     [4];
  logic signed [63:0] cacc_q [4];
  logic signed [31:0] tp_q, tn_q;
  logic signed [47:0] pacc_q [3];
  logic signed [47:0] nacc_q [3];
  logic signed [31:0] opa    [4];
  logic signed [31:0] opb    [4];

  logic [JW-1:0] jbase;
  logic [AW-1:0] addr_ld, addr_i, addr_k;
  logic          ok;
  logic          out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_i;
      joint_q <= joint_i;
      row_q   <= row_i;
      e_q[0]  <= e0_i;
      e_q[1]  <= e1_i;
      e_q[2]  <= e2_i;
      e_q[3]  <= e3_i;
      n_q[0]  <= normal_x_i;
      n_q[1]  <= normal_y_i;
      n_q[2]  <= normal_z_i;
      last_q  <= last_influence_i;
    end
  end

  assign ok    = ({3'b0, joint_q} < 9'(JOINTS));
  assign jbase = JW'(joint_q) * JW'(3);
  assign addr_ld = AW'(jbase + JW'(row_q));
  assign addr_i  = AW'(jbase + JW'(cmd_i.row_i));
  assign addr_k  = AW'(jbase + JW'(cmd_i.row_k));

  assign out_free = !out_valid_o || !out_stall_i;
  assign status_o.kind     = kind_q;
  assign status_o.ok       = ok;
  assign status_o.last     = last_q;
  assign status_o.out_free = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_load && ok && row_q != 2'd3) begin
      if (kind_q == lbs_pkg::KindPose) begin
        pose_mem[addr_ld] <= {e_q[3], e_q[2], e_q[1], e_q[0]};
      end else begin
        bind_mem[addr_ld] <= {e_q[3], e_q[2], e_q[1], e_q[0]};
      end
    end
    if (cmd_i.rd_cmp) begin
      pose_rd_q <= pose_mem[addr_i];
      bind_rd_q <= bind_mem[addr_k];
    end
    if (cmd_i.wr_skin) begin
      skin_mem[addr_i] <= {sat32(cacc_q[3]), sat32(cacc_q[2]),
                           sat32(cacc_q[1]), sat32(cacc_q[0])};
    end
    if (cmd_i.rd_skin) begin
      skin_rd_q <= skin_mem[addr_i];
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      opa[l] = '0;
      opb[l] = '0;
    end
    unique case (cmd_i.mul_sel)
      lbs_pkg::MS_CMP: begin
        for (int l = 0; l < 4; l++) begin
          opa[l] = pose_rd_q[32*cmd_i.row_k +: 32];
          opb[l] = bind_rd_q[32*l +: 32];
        end
      end
      lbs_pkg::MS_POS: begin
        for (int l = 0; l < 3; l++) begin
          opa[l] = skin_rd_q[32*l +: 32];
          opb[l] = e_q[l];
        end
      end
      lbs_pkg::MS_NRM: begin
        for (int l = 0; l < 3; l++) begin
          opa[l] = skin_rd_q[32*l +: 32];
          opb[l] = n_q[l];
        end
      end
      default: begin
        opa[0] = e_q[3];
        opb[0] = tp_q;
        opa[1] = e_q[3];
        opb[1] = tn_q;
      end
    endcase
    for (int l = 0; l < 4; l++) begin
      sh[l] = prod_q[l] >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 4; l++) begin
      prod_q[l] <= 64'(opa[l]) * 64'(opb[l]);
    end
    unique case (cmd_i.acc_op)
      lbs_pkg::AO_CMP: begin
        for (int l = 0; l < 4; l++) begin
          if (cmd_i.row_k != 2'd0) cacc_q[l] <= cacc_q[l] + sh[l];
          else if (l == 3) cacc_q[l] <= 64'($signed(pose_rd_q[127:96])) + sh[l];
          else cacc_q[l] <= sh[l];
        end
      end
      lbs_pkg::AO_TP: tp_q <= sat32(64'($signed(skin_rd_q[127:96])) + sh[0] + sh[1] + sh[2]);
      lbs_pkg::AO_TN: tn_q <= sat32(sh[0] + sh[1] + sh[2]);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        pacc_q[r] <= '0;
        nacc_q[r] <= '0;
      end
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.acc_op == lbs_pkg::AO_W) begin
        pacc_q[cmd_i.acc_row] <= sat48(64'(pacc_q[cmd_i.acc_row]) + sh[0]);
        nacc_q[cmd_i.acc_row] <= sat48(64'(nacc_q[cmd_i.acc_row]) + sh[1]);
      end
      if (cmd_i.emit) begin
        for (int r = 0; r < 3; r++) begin
          pacc_q[r] <= '0;
          nacc_q[r] <= '0;
        end
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      pos_x_o <= sat32(64'(pacc_q[0]));
      pos_y_o <= sat32(64'(pacc_q[1]));
      pos_z_o <= sat32(64'(pacc_q[2]));
      nrm_x_o <= sat32(64'(nacc_q[0]));
      nrm_y_o <= sat32(64'(nacc_q[1]));
      nrm_z_o <= sat32(64'(nacc_q[2]));
    end
  end

endmodule
`default_nettype wire

FILE: rtl/linear_blend_skinning.sv
// Linear blend skinning engine, top level: joins the sequencer and the datapath.
// Depends on lbs_pkg, lbs_ctrl and lbs_datapath.
//
// Input channel (in_valid_i / in_stall_o) takes one request at a time: a pose
// row load, an inverse bind row load, a joint compose or a vertex influence.
// Output channel (out_valid_o / out_stall_i) carries one deformed vertex per
// influence marked last_influence_i.
// Each request walks the sequencer states in turn, paced by the shared
// four-lane multiplier and the single-port row stores: a load writes its row;
// a compose multiplies and accumulates three bind rows into each of three
// result rows; an influence transforms position and normal row by row, adds
// the weighted rows and emits if last. Out-of-range joints skip the work; such
// an influence still emits if last. The result sits in an output register;
// the next request is taken while it waits. An emitting influence holds until
// that register is free. Reset clears the sequencer, the vertex accumulators
// and the output valid; matrix stores are undefined until loaded.
`default_nettype none
module linear_blend_skinning #(
  parameter int unsigned JOINTS    = lbs_pkg::JointsDef,
  parameter int unsigned FRAC_BITS = lbs_pkg::FracBitsDef
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [1:0]         kind_i,
  input  wire  [5:0]         joint_i,
  input  wire  [1:0]         row_i,
  input  wire  signed [31:0] e0_i,
  input  wire  signed [31:0] e1_i,
  input  wire  signed [31:0] e2_i,
  input  wire  signed [31:0] e3_i,
  input  wire  signed [31:0] normal_x_i,
  input  wire  signed [31:0] normal_y_i,
  input  wire  signed [31:0] normal_z_i,
  input  wire                last_influence_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [31:0] nrm_x_o,
  output logic signed [31:0] nrm_y_o,
  output logic signed [31:0] nrm_z_o
);

  lbs_pkg::cmd_t    cmd;
  lbs_pkg::status_t status;

  lbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lbs_datapath #(
    .JOINTS    (JOINTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .kind_i           (kind_i),
    .joint_i          (joint_i),
    .row_i            (row_i),
    .e0_i             (e0_i),
    .e1_i             (e1_i),
    .e2_i             (e2_i),
    .e3_i             (e3_i),
    .normal_x_i       (normal_x_i),
    .normal_y_i       (normal_y_i),
    .normal_z_i       (normal_z_i),
    .last_influence_i (last_influence_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pos_x_o          (pos_x_o),
    .pos_y_o          (pos_y_o),
    .pos_z_o          (pos_z_o),
    .nrm_x_o          (nrm_x_o),
    .nrm_y_o          (nrm_y_o),
    .nrm_z_o          (nrm_z_o)
  );

endmodule
`default_nettype wire
